// ===== src/bal_pkg.sv =====
// Shared types and constants for the bounded array list.
// No dependencies; imported by every module of the block.
`default_nettype none

package bal_pkg;

	localparam int DW  = 32;              // entry width
	localparam int PW  = 6;               // position field width
	localparam int CW  = 7;               // count / limit width
	localparam int OPW = 3;               // operation code width
	localparam int GRP = 8;               // cells examined per sweep step
	localparam int FW  = $clog2(GRP);     // index width within a group

	localparam logic [CW-1:0] MAX_RESET = 7'd64;

	typedef logic [DW-1:0] word_t;

	typedef enum logic [OPW-1:0] {
		OP_SEARCH = 3'd0,
		OP_READ   = 3'd1,
		OP_APPEND = 3'd2,
		OP_INSERT = 3'd3,
		OP_REMOVE = 3'd4
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic            append_en;
		logic            insert_en;
		logic            remove_en;
		logic [PW-1:0]   pos;
		logic [CW-1:0]   cnt;
		word_t           value;
	} cell_ctl_t;

	// per-cell status back to the top
	typedef struct packed {
		logic match;
		logic at_pos;
	} cell_stat_t;

	// sweep unit status
	typedef struct packed {
		logic          any;
		logic          hit;
		logic [PW-1:0] idx;
	} sweep_stat_t;

endpackage

`default_nettype wire

// ===== src/bounded_array_list_unit.sv =====
// Bounded array list: append, insert, remove, read and search on a cell chain.
// Append, insert-at, remove and unused codes: result in the cycle after accept.
// Search and read: result set by the sweep unit, which scans the captured hit
// vector eight cells per cycle; one request at a time.
// Reset (arst_n low): count 0, limit 64, no result pending; entries untouched.
`default_nettype none

module bounded_array_list_unit
	import bal_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPW-1:0]      operation,
	input  wire logic [PW-1:0]       position,
	input  wire logic signed [DW-1:0] value,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     ok,
	output logic [PW-1:0]            found_position,
	output logic signed [DW-1:0]     read_value,
	output logic [CW-1:0]            entry_count,
	// limit register
	input  wire logic                cfg_we,
	input  wire logic [CW-1:0]       cfg_data
);

	// Sweep geometry: groups of GRP cells, vector padded to a whole group.
	localparam int NG = (DEPTH + GRP - 1) / GRP;
	localparam int MW = NG * GRP;
	localparam int BW = $clog2(MW);
	localparam int IW = $clog2(DEPTH);
	localparam int XW = (IW > CW) ? IW : CW;
	// Largest count the 7-bit counter can be asked to reach.
	localparam logic [CW-1:0] DCAP = (DEPTH > (2**CW - 1)) ? {CW{1'b1}} : CW'(DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   max_q;
	logic            search_q;

	logic            out_valid_q;
	logic            ok_q;
	logic [PW-1:0]   found_q;
	word_t           rd_q;
	logic [CW-1:0]   cnt_q;

	logic            acc;
	op_t             op;
	logic [CW-1:0]   limit;
	logic            rd_ok, app_ok, ins_ok, rem_ok;

	cell_ctl_t       ctl;
	word_t           cell_data [DEPTH];
	cell_stat_t      cell_stat [DEPTH];

	logic [MW-1:0]   mv_in;
	word_t           sel [NG][GRP];
	word_t           gw_in [NG];
	logic            sw_load, sw_step;
	sweep_stat_t     sw_stat;
	word_t           sw_word;

	logic            res_we, res_ok;
	logic [PW-1:0]   res_found;
	word_t           res_rd;
	logic [CW-1:0]   res_cnt;
	logic            app_en, ins_en, rem_en;

	assign acc   = in_valid && in_ready;
	assign op    = op_t'(operation);
	assign limit = (max_q < DCAP) ? max_q : DCAP;

	// Request checks against the live count and the active limit.
	assign rd_ok  = {1'b0, position} < count_q;
	assign app_ok = count_q < limit;
	assign ins_ok = app_ok && rd_ok;
	assign rem_ok = rd_ok;

	// Broadcast: cells act only when an update is accepted this cycle.
	assign ctl.append_en = app_en;
	assign ctl.insert_en = ins_en;
	assign ctl.remove_en = rem_en;
	assign ctl.pos       = position;
	assign ctl.cnt       = count_q;
	assign ctl.value     = value;

	// The cell chain: each cell takes its left neighbour on insert and its
	// right neighbour on remove; the ends feed back on themselves.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		bal_cell #(
			.IDX (i),
			.XW  (XW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.stat  (cell_stat[i])
		);
	end

	// Hit vector: value matches for search, the addressed cell for read.
	// Per group, pick the word at the low position bits for a read.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		for (genvar k = 0; k < GRP; k++) begin : g_bit
			if (g * GRP + k < DEPTH) begin : g_real
				assign mv_in[g*GRP+k] = (op == OP_SEARCH) ?
					cell_stat[g*GRP+k].match : (cell_stat[g*GRP+k].at_pos && rd_ok);
				assign sel[g][k] = cell_data[g*GRP+k];
			end else begin : g_pad
				assign mv_in[g*GRP+k] = 1'b0;
				assign sel[g][k]      = '0;
			end
		end
		assign gw_in[g] = sel[g][position[FW-1:0]];
	end

	bal_sweep #(
		.NG (NG),
		.BW (BW)
	) u_sweep (
		.clk   (clk),
		.load  (sw_load),
		.step  (sw_step),
		.mv_in (mv_in),
		.gw_in (gw_in),
		.stat  (sw_stat),
		.word  (sw_word)
	);

	// Next state: search and read go through the sweep, all else completes.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (op == OP_SEARCH || op == OP_READ)) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (!sw_stat.any || sw_stat.hit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller: handshake, cell enables, sweep, result.
	always_comb begin
		in_ready  = 1'b0;
		app_en    = 1'b0;
		ins_en    = 1'b0;
		rem_en    = 1'b0;
		sw_load   = 1'b0;
		sw_step   = 1'b0;
		res_we    = 1'b0;
		res_ok    = 1'b0;
		res_found = '0;
		res_rd    = '0;
		res_cnt   = count_q;
		unique case (state_q)
			ST_IDLE: begin
				// take a request once the result register is free or draining
				in_ready = !out_valid_q || out_ready;
				if (acc) begin
					unique case (op)
						OP_SEARCH, OP_READ: begin
							sw_load = 1'b1;
						end
						OP_APPEND: begin
							app_en  = app_ok;
							res_we  = 1'b1;
							res_ok  = app_ok;
							res_cnt = app_ok ? count_q + 1'b1 : count_q;
						end
						OP_INSERT: begin
							ins_en  = ins_ok;
							res_we  = 1'b1;
							res_ok  = ins_ok;
							res_cnt = ins_ok ? count_q + 1'b1 : count_q;
						end
						OP_REMOVE: begin
							rem_en  = rem_ok;
							res_we  = 1'b1;
							res_ok  = rem_ok;
							res_cnt = rem_ok ? count_q - 1'b1 : count_q;
						end
						default: begin
							// unused codes: report failure, list unchanged
							res_we = 1'b1;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				priority if (!sw_stat.any) begin
					// miss or bad read position
					res_we = 1'b1;
				end else if (sw_stat.hit) begin
					res_we    = 1'b1;
					res_ok    = 1'b1;
					res_found = search_q ? sw_stat.idx : '0;
					res_rd    = search_q ? '0 : sw_word;
				end else begin
					sw_step = 1'b1;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			max_q       <= MAX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (res_we) begin
				count_q <= res_cnt;
			end
			// a new result wins over the one being taken
			if (res_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload and request kind: no reset needed.
	always_ff @(posedge clk) begin
		if (sw_load) begin
			search_q <= (op == OP_SEARCH);
		end
		if (res_we) begin
			ok_q    <= res_ok;
			found_q <= res_found;
			rd_q    <= res_rd;
			cnt_q   <= res_cnt;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign found_position = found_q;
	assign read_value     = rd_q;
	assign entry_count    = cnt_q;

endmodule

`default_nettype wire

// ===== src/bal_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts with neighbours.
// Depends on bal_pkg.
`default_nettype none

module bal_cell
	import bal_pkg::*;
#(
	parameter int IDX = 0,
	parameter int XW  = 7
) (
	input  wire logic       clk,
	input  wire cell_ctl_t  ctl,
	input  wire word_t      left,
	input  wire word_t      right,
	output word_t           data,
	output cell_stat_t      stat
);

	localparam logic [XW-1:0] MY = XW'(IDX);

	word_t          data_q;
	word_t          data_d;
	logic [XW-1:0]  pos_x;
	logic [XW-1:0]  cnt_x;

	assign pos_x = XW'(ctl.pos);
	assign cnt_x = XW'(ctl.cnt);

	always_comb begin
		data_d = data_q;
		priority if (ctl.append_en && MY == cnt_x) begin
			data_d = ctl.value;
		end else if (ctl.insert_en && MY == pos_x) begin
			data_d = ctl.value;
		end else if (ctl.insert_en && MY > pos_x) begin
			data_d = left;
		end else if (ctl.remove_en && MY >= pos_x) begin
			data_d = right;
		end else begin
			data_d = data_q;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data        = data_q;
	assign stat.match  = (data_q == ctl.value) && (MY < cnt_x);
	assign stat.at_pos = (MY == pos_x);

endmodule

`default_nettype wire

// ===== src/bal_sweep.sv =====
// Group-wise sweep over a captured hit vector: finds the first set bit and
// hands out the word of that group. Depends on bal_pkg.
`default_nettype none

module bal_sweep
	import bal_pkg::*;
#(
	parameter int NG = 8,
	parameter int BW = 6
) (
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic                 step,
	input  wire logic [NG*GRP-1:0]    mv_in,
	input  wire word_t                gw_in [NG],
	output sweep_stat_t               stat,
	output word_t                     word
);

	localparam int MW = NG * GRP;

	logic [MW-1:0]   mv_q;
	word_t           gw_q [NG];
	logic [BW-1:0]   base_q;
	logic [GRP-1:0]  low;
	logic [FW-1:0]   ffs;
	logic [BW-1:0]   idx;
	logic [BW+PW-1:0] idx_ext;

	always_ff @(posedge clk) begin
		if (load) begin
			mv_q   <= mv_in;
			gw_q   <= gw_in;
			base_q <= '0;
		end else if (step) begin
			mv_q   <= mv_q >> GRP;
			for (int g = 0; g < NG - 1; g++) begin
				gw_q[g] <= gw_q[g + 1];
			end
			gw_q[NG-1] <= '0;
			base_q <= base_q + BW'(GRP);
		end
	end

	// first set bit of the group at the bottom of the vector
	assign low = mv_q[GRP-1:0];
	always_comb begin
		ffs = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (low[i]) begin
				ffs = FW'(i);
			end
		end
	end

	assign idx      = base_q + BW'(ffs);
	assign idx_ext  = {{PW{1'b0}}, idx};
	assign stat.any = |mv_q;
	assign stat.hit = |low;
	assign stat.idx = idx_ext[PW-1:0];
	assign word     = gw_q[0];

endmodule

`default_nettype wire

// ===== dv/bounded_array_list_unit_test.sv =====
// Self-checking testbench for bounded_array_list_unit: a directed table, then random
// phases under several list limits. Each result is checked against a behavioural
// list or a hand-written answer. Depends on bal_pkg and bounded_array_list_unit only.
`timescale 1ns / 100ps

module bounded_array_list_unit_test;
	import bal_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int MAX_GAP    = 17;
	localparam int DRAIN_WAIT = 12;    // deepest search sweep plus margin
	localparam int N_DIRECTED = 24;
	localparam int N_PHASES   = 10;
	localparam int PHASE_LEN  = 93;

	// codes the block has no operation for; it must answer with a plain failure
	localparam logic [OPW-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OPW-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OPW-1:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic          ok;
		logic [PW-1:0] found;
		word_t         rd;
		logic [CW-1:0] cnt;
	} outcome_t;

	typedef struct packed {
		logic [OPW-1:0] op;
		logic [PW-1:0]  pos;
		word_t          val;
		logic           typed;   // want holds a hand-written answer
		outcome_t       want;
	} stim_row_t;

	// operation mix of a random phase
	typedef enum logic [1:0] {
		MIX_GROW,
		MIX_EVEN,
		MIX_SHRINK
	} traffic_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [OPW-1:0]       operation;
	logic [PW-1:0]        position;
	logic signed [DW-1:0] value;
	logic                 out_valid;
	logic                 out_ready;
	logic                 ok;
	logic [PW-1:0]        found_position;
	logic signed [DW-1:0] read_value;
	logic [CW-1:0]        entry_count;
	logic                 cfg_we;
	logic [CW-1:0]        cfg_data;

	// behavioural copy of the list and its limit register
	word_t         list_mem [LIST_DEPTH];
	logic [CW-1:0] live_count;
	logic [CW-1:0] cap_reg;

	outcome_t  pending_q [$];
	stim_row_t directed_rows [N_DIRECTED];
	int        error_count;
	bit        steady_flow;   // both sides run without gaps while set

	bounded_array_list_unit #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.found_position(found_position),
		.read_value    (read_value),
		.entry_count   (entry_count),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one request to the behavioural list and return what the block must answer.
	// Only positions below the live count are ever looked at, so slots vacated by a
	// remove keep stale words that a search must not find.
	function automatic outcome_t apply_list_op(input logic [OPW-1:0] op,
			input logic [PW-1:0] pos, input word_t val);
		outcome_t    r;
		int unsigned lim;
		int          i;
		r   = '0;
		lim = (cap_reg < LIST_DEPTH) ? cap_reg : LIST_DEPTH;
		case (op)
			OP_SEARCH: begin
				for (i = 0; i < live_count && !r.ok; i++) begin
					if (list_mem[i] == val) begin
						r.ok    = 1'b1;
						r.found = i[PW-1:0];
					end
				end
			end
			OP_READ: begin
				if (pos < live_count) begin
					r.ok = 1'b1;
					r.rd = list_mem[pos];
				end
			end
			OP_APPEND: begin
				if (live_count < lim) begin
					list_mem[live_count[PW-1:0]] = val;
					live_count++;
					r.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				// a position equal to the count is rejected, not treated as append
				if (live_count < lim && pos < live_count) begin
					for (i = int'(live_count); i > pos; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = val;
					live_count++;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos < live_count) begin
					for (i = int'(pos); i + 1 < live_count; i++)
						list_mem[i] = list_mem[i + 1];
					live_count--;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.cnt = live_count;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Present one request after a random gap and hold it until accepted; the
	// expectation is queued at the accepting edge. in_valid is only lowered when
	// a gap follows, so it never toggles within one step.
	task automatic issue_request(input logic [OPW-1:0] op, input logic [PW-1:0] pos,
			input word_t val, input logic typed, input outcome_t want);
		int       gap;
		outcome_t predicted;
		gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		value     <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = apply_list_op(op, pos, val);
		pending_q.push_back(typed ? want : predicted);
	endtask

	// Write the limit register once every outstanding result has come back.
	task automatic write_limit(input logic [CW-1:0] lim);
		while (pending_q.size() != 0) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= lim;
		@(posedge clk);
		cap_reg = lim;
		cfg_we  <= 1'b0;
	endtask

	// Random requests, mostly well formed: positions mostly inside the list and
	// values often taken from it, so searches hit and shifts reach deep.
	task automatic run_phase(input int n, input traffic_t mix);
		int             k;
		int unsigned    roll;
		int unsigned    w_app, w_ins, w_rem, w_srch;
		logic [OPW-1:0] op;
		logic [PW-1:0]  pos;
		word_t          val;
		case (mix)
			MIX_GROW:   begin w_app = 55; w_ins = 20; w_rem = 5;  w_srch = 8;  end
			MIX_EVEN:   begin w_app = 20; w_ins = 15; w_rem = 25; w_srch = 17; end
			default:    begin w_app = 8;  w_ins = 7;  w_rem = 50; w_srch = 15; end
		endcase
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < w_app)
				op = OP_APPEND;
			else if (roll < w_app + w_ins)
				op = OP_INSERT;
			else if (roll < w_app + w_ins + w_rem)
				op = OP_REMOVE;
			else if (roll < w_app + w_ins + w_rem + w_srch)
				op = OP_SEARCH;
			else if (roll < 95)
				op = OP_READ;
			else
				op = OPW'($urandom_range(OP_SPARE5, OP_SPARE7));

			roll = $urandom_range(0, 7);
			if (roll == 0 || live_count == 0)
				pos = PW'($urandom_range(0, LIST_DEPTH - 1));
			else if (roll == 1)
				pos = live_count[PW-1:0];   // one past the end
			else
				pos = PW'($urandom_range(0, live_count - 1));

			roll = $urandom_range(0, 2);
			if (roll == 0 && live_count != 0)
				val = list_mem[$urandom_range(0, live_count - 1)];
			else if (roll == 1)
				val = word_t'($signed($urandom_range(0, 7)) - 4);   // small, repeats often
			else
				val = $urandom;

			issue_request(op, pos, val, 1'b0, '0);
		end
		in_valid <= 1'b0;
	endtask

	// Result side: stall at random, then check each result as it is taken.
	initial begin
		int       stall;
		outcome_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending (ok=%0b count=%0d)",
					ok, entry_count));
			end else begin
				want = pending_q.pop_front();
				if (ok !== want.ok)
					report_mismatch($sformatf("ok %0b, want %0b", ok, want.ok));
				if (found_position !== want.found)
					report_mismatch($sformatf("found_position %0d, want %0d",
						found_position, want.found));
				if (read_value !== want.rd)
					report_mismatch($sformatf("read_value %h, want %h", read_value, want.rd));
				if (entry_count !== want.cnt)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						entry_count, want.cnt));
			end
		end
	end

	// Directed rows, some hand-checked: empty list, extreme values and
	// positions, full misses, an insert at a position equal to the count, spare
	// codes, and a search for a stale word left above the count by a remove.
	initial begin
		directed_rows = '{
			'{OP_READ,   6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd0}},
			'{OP_REMOVE, 6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd0}},
			'{OP_SEARCH, 6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd0}},
			'{OP_INSERT, 6'd0,  32'h0000_0005, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd0}},
			'{OP_APPEND, 6'd0,  32'h7FFF_FFFF, 1'b1, '{1'b1, 6'd0, 32'h0, 7'd1}},
			'{OP_APPEND, 6'd0,  32'h8000_0000, 1'b1, '{1'b1, 6'd0, 32'h0, 7'd2}},
			'{OP_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd0, 32'h0, 7'd3}},
			'{OP_SEARCH, 6'd0,  32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd2, 32'h0, 7'd3}},
			'{OP_SEARCH, 6'd0,  32'h8000_0000, 1'b1, '{1'b1, 6'd1, 32'h0, 7'd3}},
			'{OP_READ,   6'd0,  32'h0000_0000, 1'b1, '{1'b1, 6'd0, 32'h7FFF_FFFF, 7'd3}},
			'{OP_READ,   6'd63, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_INSERT, 6'd3,  32'h0000_0001, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_INSERT, 6'd0,  32'h0000_0000, 1'b0, '0},
			'{OP_READ,   6'd1,  32'h0000_0000, 1'b0, '0},
			'{OP_SEARCH, 6'd0,  32'h0000_0000, 1'b0, '0},
			'{OP_REMOVE, 6'd3,  32'h0000_0000, 1'b0, '0},
			'{OP_REMOVE, 6'd3,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_SPARE5, 6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_SPARE7, 6'd63, 32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_SPARE6, 6'd21, 32'hAAAA_AAAA, 1'b1, '{1'b0, 6'd0, 32'h0, 7'd3}},
			'{OP_REMOVE, 6'd0,  32'h0000_0000, 1'b0, '0},
			'{OP_READ,   6'd0,  32'h0000_0000, 1'b0, '0},
			'{OP_SEARCH, 6'd0,  32'hFFFF_FFFF, 1'b0, '0},
			'{OP_SEARCH, 6'd0,  32'h0001_2345, 1'b0, '0}
		};
	end

	// Main sequence: reset, directed table, then phases of random traffic,
	// each under its own limit. The limits include zero, one, the full depth
	// and the all-ones register value; a low limit after a full list covers
	// the case where the limit drops below the count and growth must fail.
	initial begin
		logic [CW-1:0] phase_limit [N_PHASES];
		traffic_t      phase_mix [N_PHASES];
		int            p;
		int            r;

		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = '0;
		position    = '0;
		value       = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_data    = '0;
		live_count  = '0;
		cap_reg     = MAX_RESET;
		error_count = 0;
		steady_flow = 1'b0;

		phase_limit = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd1, 7'd33, 7'd64, 7'd2,
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
		phase_mix   = '{MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_GROW, MIX_EVEN, MIX_GROW,
			MIX_SHRINK, MIX_EVEN, traffic_t'($urandom_range(0, 2)),
			traffic_t'($urandom_range(0, 2))};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run under the reset limit
		for (r = 0; r < N_DIRECTED; r++)
			issue_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
				directed_rows[r].typed, directed_rows[r].want);
		in_valid <= 1'b0;

		for (p = 0; p < N_PHASES; p++) begin
			write_limit(phase_limit[p]);
			// hold both sides gapless for a couple of phases
			steady_flow = (p == 3 || p == 7);
			run_phase(PHASE_LEN, phase_mix[p]);
		end

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
